// File: hdl/light_channel_auto_calibrate_defines.svh
// assertion macros for the light channel calibration checker
// no dependencies, included by the checker file
`ifndef LIGHT_CHANNEL_AUTO_CALIBRATE_DEFINES_SVH
`define LIGHT_CHANNEL_AUTO_CALIBRATE_DEFINES_SVH

// same-cycle implication
`define LCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lca check failed");

// next-cycle implication
`define LCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lca check failed");

`endif

// File: hdl/lca_pkg.sv
// shared constants, codes and interface structs for light channel calibration
// no dependencies
package lca_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 1;
  localparam int STATE_DEPTH  = 2 ** CH_W;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 17;
  localparam int WIN_W        = 4;
  localparam int FULL_SCALE   = 65536;
  localparam int DIV_STEPS    = SAMPLE_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [LEVEL_W-1:0] EPS_RESET    = LEVEL_W'(655);
  localparam logic [LEVEL_W-1:0] MARGIN_RESET = LEVEL_W'(6554);
  localparam logic [WIN_W-1:0]   WLEN_RESET   = WIN_W'(3);

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LEVEL  = 2'd1,
    EV_ACTIVE = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    CFG_EPSILON = 2'd0,
    CFG_MARGIN  = 2'd1,
    CFG_WINDOW  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_DIV,
    ST_WRAP
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] eps;
    logic [LEVEL_W-1:0] margin;
    logic [WIN_W-1:0]   wlen;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic                zero;
    logic [SAMPLE_W-1:0] dividend;
    logic [SAMPLE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                mark_we;
    logic                wrap_we;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]  norm;
  } track_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dividend;
    logic [SAMPLE_W-1:0] divisor;
    logic                zero;
    event_t              ev;
    logic [LEVEL_W-1:0]  level;
  } track_rsp_t;

endpackage

// File: hdl/lca_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on lca_pkg
module lca_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  lca_pkg::div_req_t req,
  output lca_pkg::div_rsp_t rsp
);

  logic                             busy_r, busy_nxt;
  logic [lca_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [lca_pkg::SAMPLE_W-1:0]     rem_r, rem_nxt;
  logic [lca_pkg::SAMPLE_W-1:0]     div_r, div_nxt;
  logic [lca_pkg::LEVEL_W-1:0]      quo_r, quo_nxt;
  logic [lca_pkg::SAMPLE_W:0]       rem_sh;
  logic                             qbit;
  logic                             top_bit;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r, 1'b0};
    qbit     = rem_sh >= {1'b0, div_r};
    top_bit  = req.dividend >= req.divisor;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.divisor;
      if (req.zero) begin
        cnt_nxt = '0;
        rem_nxt = '0;
        quo_nxt = '0;
      end else begin
        cnt_nxt = lca_pkg::DIV_CNT_W'(lca_pkg::DIV_STEPS);
        rem_nxt = top_bit ? (req.dividend - req.divisor) : req.dividend;
        quo_nxt = {{(lca_pkg::LEVEL_W-1){1'b0}}, top_bit};
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - lca_pkg::DIV_CNT_W'(1);
        rem_nxt = qbit ? lca_pkg::SAMPLE_W'(rem_sh - {1'b0, div_r})
                       : lca_pkg::SAMPLE_W'(rem_sh);
        quo_nxt = {quo_r[lca_pkg::LEVEL_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = busy_r && (cnt_r == '0);
  assign rsp.quotient = quo_r;

endmodule

// File: hdl/lca_track.sv
// per-channel calibration marks, window peak and report state
// depends on lca_pkg
module lca_track (
  input  logic                clk,
  input  logic                rst_n,
  input  lca_pkg::cfg_t       cfg,
  input  lca_pkg::track_req_t req,
  output lca_pkg::track_rsp_t rsp
);

  logic [lca_pkg::LEVEL_W-1:0]  low_mark_r   [lca_pkg::STATE_DEPTH];
  logic [lca_pkg::SAMPLE_W-1:0] high_mark_r  [lca_pkg::STATE_DEPTH];
  logic [lca_pkg::WIN_W-1:0]    window_cnt_r [lca_pkg::STATE_DEPTH];
  logic [lca_pkg::LEVEL_W-1:0]  peak_r       [lca_pkg::STATE_DEPTH];
  logic [lca_pkg::LEVEL_W-1:0]  last_r       [lca_pkg::STATE_DEPTH];
  logic                         active_r     [lca_pkg::STATE_DEPTH];

  logic                         ch_ok;
  logic [lca_pkg::LEVEL_W-1:0]  low_new;
  logic [lca_pkg::SAMPLE_W-1:0] high_new;
  logic [lca_pkg::LEVEL_W-1:0]  peak_new;
  logic [lca_pkg::WIN_W:0]      cnt_inc;
  logic                         win_end;
  logic [lca_pkg::LEVEL_W-1:0]  diff;
  logic [lca_pkg::LEVEL_W:0]    act_sum;
  logic                         report;
  logic                         activate;

  always_comb begin
    ch_ok    = int'(req.ch) < lca_pkg::NUM_CHANNELS;
    high_new = (req.sample > high_mark_r[req.ch]) ? req.sample : high_mark_r[req.ch];
    low_new  = ({1'b0, req.sample} < low_mark_r[req.ch]) ? {1'b0, req.sample}
                                                          : low_mark_r[req.ch];
    peak_new = (req.norm > peak_r[req.ch]) ? req.norm : peak_r[req.ch];
    cnt_inc  = {1'b0, window_cnt_r[req.ch]} + (lca_pkg::WIN_W+1)'(1);
    win_end  = cnt_inc >= {1'b0, cfg.wlen};
    diff     = (last_r[req.ch] > peak_new) ? (last_r[req.ch] - peak_new)
                                           : (peak_new - last_r[req.ch]);
    act_sum  = {1'b0, peak_new} + {1'b0, cfg.margin};
    report   = ch_ok && win_end && active_r[req.ch] && (diff > cfg.eps);
    activate = ch_ok && win_end && !active_r[req.ch] &&
               (act_sum > (lca_pkg::LEVEL_W+1)'(lca_pkg::FULL_SCALE));

    rsp.dividend = req.sample - low_new[lca_pkg::SAMPLE_W-1:0];
    rsp.divisor  = high_new;
    rsp.zero     = !ch_ok || (high_new == '0);
    rsp.ev       = report ? lca_pkg::EV_LEVEL : (activate ? lca_pkg::EV_ACTIVE
                                                          : lca_pkg::EV_NONE);
    rsp.level    = report ? peak_new : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < lca_pkg::STATE_DEPTH; c++) begin
        low_mark_r[c]   <= lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE);
        high_mark_r[c]  <= '0;
        window_cnt_r[c] <= lca_pkg::WIN_W'(c);
        peak_r[c]       <= '0;
        last_r[c]       <= '0;
        active_r[c]     <= 1'b0;
      end
    end else if (ch_ok) begin
      if (req.mark_we) begin
        low_mark_r[req.ch]  <= low_new;
        high_mark_r[req.ch] <= high_new;
      end
      if (req.wrap_we) begin
        if (win_end) begin
          window_cnt_r[req.ch] <= '0;
          peak_r[req.ch]       <= '0;
        end else begin
          window_cnt_r[req.ch] <= cnt_inc[lca_pkg::WIN_W-1:0];
          peak_r[req.ch]       <= peak_new;
        end
        if (report) begin
          last_r[req.ch] <= peak_new;
        end
        if (activate) begin
          active_r[req.ch] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/light_channel_auto_calibrate.sv
// flow: an input beat passes the mark, divide and wrap steps before its result beat
// is registered; with a zero maximum the 16-step serial divider skips its steps, and no
// new input is taken before the wrap step; a stalled result beat holds the wrap step
// reset: synchronous active-low, state, config and valid registers return to defaults, every channel
// inactive with low mark at full scale and staggered window counts
module light_channel_auto_calibrate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lca_pkg::CH_W-1:0]      in_channel,
  input  logic [lca_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lca_pkg::CH_W-1:0]      out_channel_out,
  output logic [lca_pkg::LEVEL_W-1:0]   out_normalized,
  output logic [1:0]                    out_event_res,
  output logic [lca_pkg::LEVEL_W-1:0]   out_level,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lca_pkg::LEVEL_W-1:0]   cfg_data
);

  lca_pkg::state_t              state_r, state_nxt;
  lca_pkg::cfg_t                cfg_r, cfg_nxt;
  logic [lca_pkg::CH_W-1:0]     ch_r;
  logic [lca_pkg::SAMPLE_W-1:0] sample_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [lca_pkg::CH_W-1:0]     out_ch_r;
  logic [lca_pkg::LEVEL_W-1:0]  out_norm_r;
  logic [1:0]                   out_ev_r;
  logic [lca_pkg::LEVEL_W-1:0]  out_level_r;
  logic                         in_beat;
  logic                         wrap_go;

  lca_pkg::div_req_t   div_req;
  lca_pkg::div_rsp_t   div_rsp;
  lca_pkg::track_req_t trk_req;
  lca_pkg::track_rsp_t trk_rsp;

  assign in_ready = (state_r == lca_pkg::ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign wrap_go  = (state_r == lca_pkg::ST_WRAP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lca_pkg::ST_IDLE: if (in_valid) state_nxt = lca_pkg::ST_MARK;
      lca_pkg::ST_MARK: state_nxt = lca_pkg::ST_DIV;
      lca_pkg::ST_DIV:  if (div_rsp.done) state_nxt = lca_pkg::ST_WRAP;
      lca_pkg::ST_WRAP: if (wrap_go) state_nxt = lca_pkg::ST_IDLE;
      default:          state_nxt = lca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lca_pkg::CFG_EPSILON: cfg_nxt.eps    = cfg_data;
        lca_pkg::CFG_MARGIN:  cfg_nxt.margin = cfg_data;
        lca_pkg::CFG_WINDOW:  cfg_nxt.wlen   = cfg_data[lca_pkg::WIN_W-1:0];
        default:              cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_comb begin
    trk_req.mark_we = (state_r == lca_pkg::ST_MARK);
    trk_req.wrap_we = wrap_go;
    trk_req.ch      = ch_r;
    trk_req.sample  = sample_r;
    trk_req.norm    = div_rsp.quotient;

    div_req.start    = (state_r == lca_pkg::ST_MARK);
    div_req.zero     = trk_rsp.zero;
    div_req.dividend = trk_rsp.dividend;
    div_req.divisor  = trk_rsp.divisor;

    out_valid_nxt = out_valid_r;
    if (wrap_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lca_pkg::ST_IDLE;
      cfg_r.eps    <= lca_pkg::EPS_RESET;
      cfg_r.margin <= lca_pkg::MARGIN_RESET;
      cfg_r.wlen   <= lca_pkg::WLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_beat) begin
      ch_r     <= in_channel;
      sample_r <= in_sample;
    end
    if (wrap_go) begin
      out_ch_r    <= ch_r;
      out_norm_r  <= div_rsp.quotient;
      out_ev_r    <= trk_rsp.ev;
      out_level_r <= trk_rsp.level;
    end
  end

  lca_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lca_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (trk_req),
    .rsp   (trk_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_normalized  = out_norm_r;
  assign out_event_res   = out_ev_r;
  assign out_level       = out_level_r;

endmodule

// File: hdl/lca_checker.sv
// port-level checks for light_channel_auto_calibrate, bound to the top level
// depends on lca_pkg and light_channel_auto_calibrate_defines.svh
`include "light_channel_auto_calibrate_defines.svh"

module lca_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lca_pkg::CH_W-1:0]      out_channel_out,
  input logic [lca_pkg::LEVEL_W-1:0]   out_normalized,
  input logic [1:0]                    out_event_res,
  input logic [lca_pkg::LEVEL_W-1:0]   out_level
);

  // stalled result beat holds
  `LCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_normalized) && $stable(out_level) && $stable(out_event_res) && $stable(out_channel_out))

  // one item in flight
  `LCA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // activation beat carries no level
  `LCA_ASSERT_NOW(a_active_no_level, out_valid && (out_event_res == lca_pkg::EV_ACTIVE), out_level == '0)

  // normalized level never above full scale
  `LCA_ASSERT_NOW(a_norm_range, out_valid && out_normalized[lca_pkg::LEVEL_W-1], out_normalized[lca_pkg::LEVEL_W-2:0] == '0)

endmodule

bind light_channel_auto_calibrate lca_checker u_lca_checker (.*);

// File: bench/light_channel_auto_calibrate_tb.sv
// testbench for light_channel_auto_calibrate: directed and random light sample streams
// every result beat is checked field by field against an in-bench calibration predictor
// depends on lca_pkg and the light_channel_auto_calibrate rtl
module light_channel_auto_calibrate_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 150;

  typedef struct {
    logic [lca_pkg::CH_W-1:0]    ch;
    logic [lca_pkg::LEVEL_W-1:0] norm;
    lca_pkg::event_t             ev;
    logic [lca_pkg::LEVEL_W-1:0] level;
  } cal_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lca_pkg::CH_W-1:0]     in_channel = '0;
  logic [lca_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [lca_pkg::CH_W-1:0]     out_channel_out;
  logic [lca_pkg::LEVEL_W-1:0]  out_normalized;
  logic [1:0]                   out_event_res;
  logic [lca_pkg::LEVEL_W-1:0]  out_level;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_index = '0;
  logic [lca_pkg::LEVEL_W-1:0]  cfg_data = '0;

  logic [lca_pkg::LEVEL_W-1:0]  eps_q;
  logic [lca_pkg::LEVEL_W-1:0]  margin_q;
  logic [lca_pkg::WIN_W-1:0]    wlen_q;
  logic [lca_pkg::LEVEL_W-1:0]  low_mark_q [lca_pkg::NUM_CHANNELS];
  logic [lca_pkg::SAMPLE_W-1:0] high_mark_q [lca_pkg::NUM_CHANNELS];
  logic [lca_pkg::WIN_W-1:0]    win_count_q [lca_pkg::NUM_CHANNELS];
  logic [lca_pkg::LEVEL_W-1:0]  win_peak_q [lca_pkg::NUM_CHANNELS];
  logic [lca_pkg::LEVEL_W-1:0]  last_level_q [lca_pkg::NUM_CHANNELS];
  logic                         chan_active_q [lca_pkg::NUM_CHANNELS];

  cal_result_t pending_results[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          rx_hold = 0;
  bit          rx_stall_en = 1'b1;
  bit          tx_gap_en = 1'b1;

  light_channel_auto_calibrate i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_normalized  (out_normalized),
    .out_event_res   (out_event_res),
    .out_level       (out_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_calibration();
    eps_q = lca_pkg::EPS_RESET;
    margin_q = lca_pkg::MARGIN_RESET;
    wlen_q = lca_pkg::WLEN_RESET;
    for (int c = 0; c < lca_pkg::NUM_CHANNELS; c++) begin
      low_mark_q[c] = lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE);
      high_mark_q[c] = '0;
      win_count_q[c] = lca_pkg::WIN_W'(c);
      win_peak_q[c] = '0;
      last_level_q[c] = '0;
      chan_active_q[c] = 1'b0;
    end
  endfunction

  function automatic cal_result_t calibrate_sample(logic [lca_pkg::CH_W-1:0] ch,
                                                   logic [lca_pkg::SAMPLE_W-1:0] s);
    cal_result_t                 r;
    longint unsigned             quo;
    logic [lca_pkg::WIN_W:0]     cnt;
    logic [lca_pkg::LEVEL_W-1:0] pk;
    logic [lca_pkg::LEVEL_W-1:0] diff;
    r.ch = ch;
    r.norm = '0;
    r.ev = lca_pkg::EV_NONE;
    r.level = '0;
    if (int'(ch) >= lca_pkg::NUM_CHANNELS) return r;
    if (s > high_mark_q[ch]) high_mark_q[ch] = s;
    if ({1'b0, s} < low_mark_q[ch]) low_mark_q[ch] = {1'b0, s};
    if (high_mark_q[ch] != 0 && {1'b0, s} >= low_mark_q[ch]) begin
      quo = ((64'(s) - 64'(low_mark_q[ch])) << 16) / 64'(high_mark_q[ch]);
      r.norm = (quo > lca_pkg::FULL_SCALE) ? lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE)
                                           : lca_pkg::LEVEL_W'(quo);
    end
    if (r.norm > win_peak_q[ch]) win_peak_q[ch] = r.norm;
    cnt = {1'b0, win_count_q[ch]} + 1'b1;
    if (cnt >= {1'b0, wlen_q}) begin
      pk = win_peak_q[ch];
      if (chan_active_q[ch]) begin
        diff = (last_level_q[ch] > pk) ? last_level_q[ch] - pk : pk - last_level_q[ch];
        if (diff > eps_q) begin
          r.ev = lca_pkg::EV_LEVEL;
          r.level = pk;
          last_level_q[ch] = pk;
        end
      end else if (int'(pk) > lca_pkg::FULL_SCALE - int'(margin_q)) begin
        chan_active_q[ch] = 1'b1;
        r.ev = lca_pkg::EV_ACTIVE;
      end
      win_count_q[ch] = '0;
      win_peak_q[ch] = '0;
    end else begin
      win_count_q[ch] = cnt[lca_pkg::WIN_W-1:0];
    end
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int pick_gap();
    return ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
  endfunction

  function automatic logic [lca_pkg::LEVEL_W-1:0] pick_q16_reg();
    case ($urandom_range(4))
      0: return '0;
      1: return lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE);
      2: return '1;
      3: return lca_pkg::LEVEL_W'($urandom_range(2000));
      default: return lca_pkg::LEVEL_W'($urandom_range(131071));
    endcase
  endfunction

  function automatic logic [lca_pkg::WIN_W-1:0] pick_window();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return lca_pkg::WIN_W'($urandom_range(5, 1));
      default: return lca_pkg::WIN_W'($urandom_range(15));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic send_sample(input logic [lca_pkg::CH_W-1:0] ch,
                             input logic [lca_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = (tx_gap_en && $urandom_range(99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(calibrate_sample(ch, s));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || !in_ready);
  endtask

  task automatic write_config(input logic [lca_pkg::LEVEL_W-1:0] eps,
                              input logic [lca_pkg::LEVEL_W-1:0] margin,
                              input logic [lca_pkg::WIN_W-1:0] wlen);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= lca_pkg::CFG_EPSILON;
    cfg_data <= eps;
    @(posedge clk);
    cfg_index <= lca_pkg::CFG_MARGIN;
    cfg_data <= margin;
    @(posedge clk);
    // upper bits are don't-care for the window register
    cfg_index <= lca_pkg::CFG_WINDOW;
    cfg_data <= lca_pkg::LEVEL_W'({$urandom(), wlen});
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_q = eps;
    margin_q = margin;
    wlen_q = wlen;
  endtask

  task automatic test_reset_defaults();
    // zero maximum on channel 0, window closes without activation
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd0);
    // staggered window on channel 1, then activation at full scale
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b1, 16'd32768);
    send_sample(1'b1, 16'hFFFF);
  endtask

  task automatic test_window_extremes();
    write_config('0, lca_pkg::MARGIN_RESET, '0);
    send_sample(1'b1, 16'd20000);
    send_sample(1'b1, 16'd20000);
    send_sample(1'b1, 16'hFFFF);
    write_config('0, lca_pkg::MARGIN_RESET, '1);
    repeat (5) send_sample(1'b1, lca_pkg::SAMPLE_W'($urandom()));
    // count already past the new length
    write_config('0, lca_pkg::MARGIN_RESET, lca_pkg::WIN_W'(2));
    send_sample(1'b1, 16'd40000);
  endtask

  task automatic test_margin_extremes();
    write_config(lca_pkg::EPS_RESET, '0, lca_pkg::WIN_W'(1));
    send_sample(1'b0, 16'hFFFF);
    write_config(lca_pkg::EPS_RESET, lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE),
                 lca_pkg::WIN_W'(1));
    send_sample(1'b0, 16'd0);
    // negative threshold, any peak activates
    write_config(lca_pkg::EPS_RESET, '1, lca_pkg::WIN_W'(1));
    send_sample(1'b0, 16'd0);
  endtask

  task automatic test_epsilon_extremes();
    write_config(lca_pkg::LEVEL_W'(lca_pkg::FULL_SCALE), lca_pkg::MARGIN_RESET,
                 lca_pkg::WIN_W'(1));
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'hFFFF);
    write_config('1, lca_pkg::MARGIN_RESET, lca_pkg::WIN_W'(1));
    send_sample(1'b0, 16'd32768);
    write_config('0, lca_pkg::MARGIN_RESET, lca_pkg::WIN_W'(1));
    send_sample(1'b0, 16'hFFFF);
    send_sample(1'b0, 16'd0);
  endtask

  task automatic test_random_traffic();
    int                           drift [lca_pkg::NUM_CHANNELS];
    logic [lca_pkg::CH_W-1:0]     ch;
    logic [lca_pkg::SAMPLE_W-1:0] s;
    for (int c = 0; c < lca_pkg::NUM_CHANNELS; c++) drift[c] = $urandom_range(65535);
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_config(pick_q16_reg(), pick_q16_reg(), pick_window());
      rx_stall_en = (phase != 1);
      tx_gap_en = (phase != 2);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        ch = lca_pkg::CH_W'($urandom_range(lca_pkg::NUM_CHANNELS - 1));
        case ($urandom_range(9))
          0: s = '0;
          1: s = '1;
          2, 3: s = lca_pkg::SAMPLE_W'($urandom());
          default: begin
            // slowly moving light level
            drift[ch] = drift[ch] + int'($urandom_range(4000)) - 2000;
            if (drift[ch] < 0) drift[ch] = 0;
            if (drift[ch] > 65535) drift[ch] = 65535;
            s = lca_pkg::SAMPLE_W'(drift[ch]);
          end
        endcase
        if ($urandom_range(99) == 0) drain_results();
        send_sample(ch, s);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rx_stall_en) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < 20) begin
      rx_hold = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beat
    cal_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing expected", out_normalized, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_channel_out !== want.ch)
          report_mismatch("channel_out", out_channel_out, want.ch);
        if (out_normalized !== want.norm)
          report_mismatch("normalized", out_normalized, want.norm);
        if (out_event_res !== want.ev)
          report_mismatch("event_res", out_event_res, want.ev);
        if (out_level !== want.level)
          report_mismatch("level", out_level, want.level);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    reset_calibration();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_window_extremes();
    test_margin_extremes();
    test_epsilon_extremes();
    test_random_traffic();
    drain_results();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
